[src/mdfh_pkg.sv]
package mdfh_pkg;

  // Number of id bytes sent by read device id, capped at the largest response.
  localparam int unsigned IdLen   = 25;
  localparam int unsigned ResMax  = 25;
  localparam int unsigned IdCount = (IdLen > ResMax) ? ResMax : ((IdLen < 1) ? 1 : IdLen);

  localparam int unsigned NumCoils  = 4;
  localparam int unsigned NumInputs = 8;

  localparam int unsigned CfgW  = 11;
  localparam int unsigned CntW  = 5;
  localparam int unsigned AddrW = 4;

  typedef enum logic [2:0] {
    CMD_READ_COILS  = 3'd0,
    CMD_READ_INPUTS = 3'd1,
    CMD_WRITE_COIL  = 3'd2,
    CMD_WRITE_COILS = 3'd3,
    CMD_READ_ID     = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ADDR  = 2'd1,
    ST_VALUE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_MAX_READ_COILS  = 2'd0,
    REG_MAX_READ_INPUTS = 2'd1,
    REG_MAX_WRITE_COILS = 2'd2
  } reg_e;

  typedef struct packed {
    logic [7:0]  input_pins;
    logic [7:0]  object_id;
    logic [7:0]  read_code;
    logic [7:0]  coil_data;
    logic [7:0]  byte_count;
    logic [15:0] quantity;
    logic [7:0]  addr_lo;
    logic [7:0]  addr_hi;
    logic [7:0]  frame_len;
    logic [2:0]  cmd;
  } req_t;

  // One decoded response: either a short list of bytes or the id string.
  typedef struct packed {
    status_e         status;
    logic            is_id;
    logic [CntW-1:0] count;
    logic [3:0][7:0] bytes;
    logic [3:0]      relay;
  } job_t;

  typedef struct packed {
    logic emit;
    job_t job;
  } dec_t;

  function automatic logic [7:0] ident_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'h01;
      5'd1:    b = 8'h00;
      5'd2:    b = 8'h00;
      5'd3:    b = 8'h03;
      5'd4:    b = 8'h00;
      5'd5:    b = 8'h03;
      5'd6:    b = 8'h53;
      5'd7:    b = 8'h59;
      5'd8:    b = 8'h53;
      5'd9:    b = 8'h01;
      5'd10:   b = 8'h08;
      5'd11:   b = 8'h4D;
      5'd12:   b = 8'h52;
      5'd13:   b = 8'h2D;
      5'd14:   b = 8'h44;
      5'd15:   b = 8'h49;
      5'd16:   b = 8'h4F;
      5'd17:   b = 8'h38;
      5'd18:   b = 8'h34;
      5'd19:   b = 8'h02;
      5'd20:   b = 8'h04;
      5'd21:   b = 8'h56;
      5'd22:   b = 8'h31;
      5'd23:   b = 8'h2E;
      5'd24:   b = 8'h30;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[src/modbus_dio_function_handler.sv]
// Channel    Direction  Handshake                 Contents
// s_axis     in         tvalid/tready             one parsed request per item
// m_axis     out        tvalid/tready, tlast      one response byte per item
// APB        in         psel/penable/pwrite       three quantity limit registers
//
// A request is registered, decoded combinationally and handed to the response
// emitter, which sends one byte per cycle unless m_axis stalls: one item for an
// exception, two for a read, four for a write echo and 25 for the id string. The
// emitter sets the rate; the next request is taken while the current response
// drains. The relay register changes when a request is decoded. Reset clears the
// relays and loads the default limits; stalls on m_axis hold the output item.
module modbus_dio_function_handler (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // s_axis_tdata: cmd[2:0], frame_len[10:3], addr_hi[18:11], addr_lo[26:19],
  // quantity[42:27], byte_count[50:43], coil_data[58:51], read_code[66:59],
  // object_id[74:67], input_pins[82:75], zero fill[87:83]
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [87:0]               s_axis_tdata,
  // m_axis_tdata: status[1:0], resp_byte[9:2], relay_drive[13:10], zero fill[15:14]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [15:0]               m_axis_tdata,
  output logic                      m_axis_tlast,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [mdfh_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mdfh_pkg::*;

  logic [CfgW-1:0] max_rc_q, max_ri_q, max_wc_q;
  logic            cfg_wr;
  reg_e            cfg_sel;

  logic            in_valid_q;
  req_t            in_q;
  logic            in_adv;

  dec_t            dec;
  logic [3:0]      relay_q;

  logic            job_valid_q;
  job_t            job_q;
  logic [CntW-1:0] idx_q;
  logic            out_ready;
  logic            emit;
  logic            job_last;
  logic            job_free;
  logic [7:0]      emit_byte;

  logic            out_valid_q;
  logic [1:0]      out_status_q;
  logic [7:0]      out_byte_q;
  logic            out_last_q;
  logic [3:0]      out_relay_q;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = reg_e'(paddr[3:2]);

  always_comb begin
    case (cfg_sel)
      REG_MAX_READ_COILS:  prdata = {21'b0, max_rc_q};
      REG_MAX_READ_INPUTS: prdata = {21'b0, max_ri_q};
      REG_MAX_WRITE_COILS: prdata = {21'b0, max_wc_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rc_q <= CfgW'(4);
      max_ri_q <= CfgW'(8);
      max_wc_q <= CfgW'(4);
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_MAX_READ_COILS:  max_rc_q <= pwdata[CfgW-1:0];
        REG_MAX_READ_INPUTS: max_ri_q <= pwdata[CfgW-1:0];
        REG_MAX_WRITE_COILS: max_wc_q <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign emit          = job_valid_q && out_ready;
  assign job_last      = (idx_q == job_q.count - CntW'(1));
  assign job_free      = !job_valid_q || (emit && job_last);
  assign in_adv        = in_valid_q && job_free;
  assign s_axis_tready = !in_valid_q || in_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q <= req_t'(s_axis_tdata[$bits(req_t)-1:0]);
    end
  end

  mdfh_decode u_decode (
    .req_i             (in_q),
    .max_read_coils_i  (max_rc_q),
    .max_read_inputs_i (max_ri_q),
    .max_write_coils_i (max_wc_q),
    .relay_i           (relay_q),
    .dec_o             (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relay_q <= '0;
    end else if (in_adv) begin
      relay_q <= dec.job.relay;
    end
  end

  // Response emitter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= '0;
    end else if (in_adv && dec.emit) begin
      job_valid_q <= 1'b1;
      idx_q       <= '0;
    end else if (emit) begin
      job_valid_q <= !job_last;
      idx_q       <= idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && dec.emit) begin
      job_q <= dec.job;
    end
  end

  assign emit_byte = job_q.is_id ? ident_byte(idx_q) : job_q.bytes[idx_q[1:0]];

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_q <= job_q.status;
      out_byte_q   <= emit_byte;
      out_last_q   <= job_last;
      out_relay_q  <= job_q.relay;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_relay_q, out_byte_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[src/mdfh_decode.sv]
module mdfh_decode (
  input  mdfh_pkg::req_t          req_i,
  input  logic [10:0]             max_read_coils_i,
  input  logic [10:0]             max_read_inputs_i,
  input  logic [10:0]             max_write_coils_i,
  input  logic [3:0]              relay_i,
  output mdfh_pkg::dec_t          dec_o
);
  import mdfh_pkg::*;

  logic [10:0] lim;
  logic [16:0] pts;
  logic [16:0] end_sum;
  logic [7:0]  rd_mask;
  logic [8:0]  rd_mask_w;
  logic [7:0]  rd_src;
  logic [7:0]  rd_bits;
  logic [16:0] bc_need;
  logic [8:0]  flen_need;
  logic [4:0]  wc_mask_w;
  logic [3:0]  wc_mask;
  logic [7:0]  wc_bits_w;
  logic [7:0]  wc_mask_sh;
  logic [3:0]  one_hot;
  job_t        exc;
  job_t        echo;

  always_comb begin
    lim       = (req_i.cmd == CMD_READ_COILS) ? max_read_coils_i : max_read_inputs_i;
    pts       = (req_i.cmd == CMD_READ_COILS) ? 17'(NumCoils) : 17'(NumInputs);
    end_sum   = {1'b0, req_i.quantity} + 17'(req_i.addr_lo);
    rd_mask_w = (9'd1 << req_i.quantity[3:0]) - 9'd1;
    rd_mask   = rd_mask_w[7:0];
    rd_src    = (req_i.cmd == CMD_READ_COILS) ? {4'b0, relay_i} : req_i.input_pins;
    rd_bits   = (rd_src >> req_i.addr_lo[2:0]) & rd_mask;

    bc_need   = ({1'b0, req_i.quantity} + 17'd7) >> 3;
    flen_need = {1'b0, req_i.byte_count} + 9'd9;
    wc_mask_w = (5'd1 << req_i.quantity[2:0]) - 5'd1;
    wc_mask   = wc_mask_w[3:0];
    wc_bits_w = {4'b0, req_i.coil_data[3:0] & wc_mask} << req_i.addr_lo[1:0];
    wc_mask_sh = {4'b0, wc_mask} << req_i.addr_lo[1:0];
    one_hot   = 4'b0001 << req_i.addr_lo[1:0];

    exc.status = ST_OK;
    exc.is_id  = 1'b0;
    exc.count  = CntW'(1);
    exc.bytes  = '0;
    exc.relay  = relay_i;

    echo.status   = ST_OK;
    echo.is_id    = 1'b0;
    echo.count    = CntW'(4);
    echo.bytes[0] = req_i.addr_hi;
    echo.bytes[1] = req_i.addr_lo;
    echo.bytes[2] = req_i.quantity[15:8];
    echo.bytes[3] = req_i.quantity[7:0];
    echo.relay    = relay_i;

    dec_o.emit = 1'b1;
    dec_o.job  = exc;

    case (req_i.cmd)
      CMD_READ_COILS, CMD_READ_INPUTS: begin
        if (req_i.frame_len != 8'd8 || req_i.quantity == 16'd0 ||
            req_i.quantity > {5'b0, lim}) begin
          dec_o.job.status = ST_VALUE;
        end else if (req_i.addr_hi != 8'd0 || 17'(req_i.addr_lo) >= pts ||
                     end_sum > pts) begin
          dec_o.job.status = ST_ADDR;
        end else begin
          dec_o.job.count    = CntW'(2);
          dec_o.job.bytes[0] = 8'd1;
          dec_o.job.bytes[1] = rd_bits;
        end
      end
      CMD_WRITE_COIL: begin
        if (req_i.frame_len != 8'd8 || req_i.quantity[7:0] != 8'd0 ||
            (req_i.quantity[15:8] != 8'h00 && req_i.quantity[15:8] != 8'hFF)) begin
          dec_o.job.status = ST_VALUE;
        end else if (req_i.addr_hi != 8'd0 || req_i.addr_lo > 8'd3) begin
          dec_o.job.status = ST_ADDR;
        end else begin
          dec_o.job = echo;
          dec_o.job.relay = req_i.quantity[15] ? (relay_i | one_hot) : (relay_i & ~one_hot);
        end
      end
      CMD_WRITE_COILS: begin
        if (req_i.frame_len < 8'd9 || req_i.quantity == 16'd0 ||
            req_i.quantity > {5'b0, max_write_coils_i} ||
            {9'b0, req_i.byte_count} != bc_need ||
            {1'b0, req_i.frame_len} != flen_need) begin
          dec_o.job.status = ST_VALUE;
        end else if (req_i.addr_hi != 8'd0 || req_i.addr_lo > 8'd3 ||
                     end_sum > 17'(NumCoils)) begin
          dec_o.job.status = ST_ADDR;
        end else begin
          dec_o.job = echo;
          dec_o.job.relay = (relay_i & ~wc_mask_sh[3:0]) | wc_bits_w[3:0];
        end
      end
      CMD_READ_ID: begin
        if (req_i.frame_len != 8'd7 || req_i.object_id != 8'd0) begin
          dec_o.job.status = ST_ADDR;
        end else if (req_i.read_code != 8'd1) begin
          dec_o.job.status = ST_VALUE;
        end else begin
          dec_o.job.is_id = 1'b1;
          dec_o.job.count = CntW'(IdCount);
        end
      end
      default: begin
        // Unknown commands are dropped without a response.
        dec_o.emit = 1'b0;
      end
    endcase
  end

endmodule

[dv/tb_modbus_dio_function_handler.sv]
module tb_modbus_dio_function_handler;
  import mdfh_pkg::*;

  localparam logic [2:0]  CMD_SPARE_LO = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI = 3'd7;
  localparam logic [15:0] COIL_ON      = 16'hFF00;
  localparam logic [15:0] COIL_OFF     = 16'h0000;
  // Longest response is the id string plus the request register and decode.
  localparam int          SETTLE_CYCLES = 40;
  localparam int          PRINT_CAP     = 100;

  localparam logic [7:0] DEVICE_ID [32] = '{
    8'h01, 8'h00, 8'h00, 8'h03, 8'h00, 8'h03, 8'h53, 8'h59, 8'h53, 8'h01, 8'h08,
    8'h4D, 8'h52, 8'h2D, 8'h44, 8'h49, 8'h4F, 8'h38, 8'h34, 8'h02, 8'h04,
    8'h56, 8'h31, 8'h2E, 8'h30, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  typedef struct {
    status_e    status;
    logic [7:0] data;
    logic       last;
    logic [3:0] relay;
  } resp_t;

  typedef struct {
    req_t    req;
    bit      typed;
    status_e st;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [87:0]         s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;
  logic                m_axis_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrW-1:0]    paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  logic [CfgW-1:0] lim_read_coils;
  logic [CfgW-1:0] lim_read_inputs;
  logic [CfgW-1:0] lim_write_coils;
  logic [3:0]      relay_state;

  resp_t staged_resp[$];
  resp_t pending_resp[$];
  row_t  dir_tab[$];
  int    mismatch_cnt = 0;
  int    s_idle_pct   = 0;
  int    r_stall_pct  = 0;
  int    hold_left    = 0;

  modbus_dio_function_handler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
  endtask

  function automatic void stage(input status_e st, input logic [7:0] data, input logic last);
    staged_resp.push_back('{st, data, last, relay_state});
  endfunction

  // Works out the response bytes of one request and applies its relay write.
  function automatic void predict_response(input req_t r);
    int unsigned q;
    int unsigned al;
    int unsigned hi;
    int unsigned pts;
    int unsigned lim;
    logic [7:0]  mask;
    logic [7:0]  bits;
    staged_resp.delete();
    q  = r.quantity;
    al = r.addr_lo;
    hi = q >> 8;
    case (r.cmd)
      CMD_READ_COILS, CMD_READ_INPUTS: begin
        lim = (r.cmd == CMD_READ_COILS) ? lim_read_coils : lim_read_inputs;
        pts = (r.cmd == CMD_READ_COILS) ? NumCoils : NumInputs;
        if (r.frame_len != 8 || q == 0 || q > lim) begin
          stage(ST_VALUE, 8'h00, 1'b1);
        end else if (r.addr_hi != 0 || al > pts - 1 || q + al > pts) begin
          stage(ST_ADDR, 8'h00, 1'b1);
        end else begin
          mask = 8'((1 << q) - 1);
          bits = (r.cmd == CMD_READ_COILS) ? {4'h0, relay_state} : r.input_pins;
          bits = (bits >> al) & mask;
          stage(ST_OK, 8'd1, 1'b0);
          stage(ST_OK, bits, 1'b1);
        end
      end
      CMD_WRITE_COIL: begin
        if (r.frame_len != 8 || r.quantity[7:0] != 0 || (hi != 0 && hi != 'hFF)) begin
          stage(ST_VALUE, 8'h00, 1'b1);
        end else if (r.addr_hi != 0 || al > 3) begin
          stage(ST_ADDR, 8'h00, 1'b1);
        end else begin
          mask = 8'(1 << al);
          relay_state = 4'((relay_state & ~mask) | (hi & mask));
          stage(ST_OK, r.addr_hi, 1'b0);
          stage(ST_OK, r.addr_lo, 1'b0);
          stage(ST_OK, r.quantity[15:8], 1'b0);
          stage(ST_OK, r.quantity[7:0], 1'b1);
        end
      end
      CMD_WRITE_COILS: begin
        if (r.frame_len < 9 || q == 0 || q > lim_write_coils ||
            r.byte_count != ((q + 7) >> 3) || r.frame_len != r.byte_count + 9) begin
          stage(ST_VALUE, 8'h00, 1'b1);
        end else if (r.addr_hi != 0 || al > 3 || q + al > NumCoils) begin
          stage(ST_ADDR, 8'h00, 1'b1);
        end else begin
          mask = 8'((1 << q) - 1);
          bits = (r.coil_data & mask) << al;
          mask = mask << al;
          relay_state = 4'((relay_state & ~mask) | bits);
          stage(ST_OK, r.addr_hi, 1'b0);
          stage(ST_OK, r.addr_lo, 1'b0);
          stage(ST_OK, r.quantity[15:8], 1'b0);
          stage(ST_OK, r.quantity[7:0], 1'b1);
        end
      end
      CMD_READ_ID: begin
        if (r.frame_len != 7 || r.object_id != 0) begin
          stage(ST_ADDR, 8'h00, 1'b1);
        end else if (r.read_code != 1) begin
          stage(ST_VALUE, 8'h00, 1'b1);
        end else begin
          for (int k = 0; k < IdCount; k++) stage(ST_OK, DEVICE_ID[k % 32], k == IdCount - 1);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic req_t mk_req(input logic [2:0] c, input logic [7:0] flen,
                                  input logic [7:0] ah, input logic [7:0] al,
                                  input logic [15:0] q, input logic [7:0] bc,
                                  input logic [7:0] cd, input logic [7:0] rc,
                                  input logic [7:0] oid, input logic [7:0] pins);
    req_t r;
    r.cmd        = c;
    r.frame_len  = flen;
    r.addr_hi    = ah;
    r.addr_lo    = al;
    r.quantity   = q;
    r.byte_count = bc;
    r.coil_data  = cd;
    r.read_code  = rc;
    r.object_id  = oid;
    r.input_pins = pins;
    return r;
  endfunction

  // Mostly well-formed requests with random payload, some with one field
  // broken, and the rest plain noise.
  function automatic req_t random_request();
    req_t        r;
    int unsigned mode;
    int unsigned pick;
    int unsigned pts;
    int unsigned al;
    r = mk_req(3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    mode = $urandom_range(99);
    if (mode < 80) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        r.cmd = (pick < 25) ? CMD_READ_COILS : CMD_READ_INPUTS;
        pts = (pick < 25) ? NumCoils : NumInputs;
        al = $urandom_range(pts - 1);
        r.frame_len = 8'd8;
        r.addr_hi   = 8'd0;
        r.addr_lo   = 8'(al);
        r.quantity  = 16'($urandom_range(pts - al, 1));
      end else if (pick < 70) begin
        r.cmd       = CMD_WRITE_COIL;
        r.frame_len = 8'd8;
        r.addr_hi   = 8'd0;
        r.addr_lo   = 8'($urandom_range(3));
        r.quantity  = $urandom_range(1) ? COIL_ON : COIL_OFF;
      end else if (pick < 90) begin
        al = $urandom_range(3);
        r.cmd        = CMD_WRITE_COILS;
        r.frame_len  = 8'd10;
        r.addr_hi    = 8'd0;
        r.addr_lo    = 8'(al);
        r.quantity   = 16'($urandom_range(NumCoils - al, 1));
        r.byte_count = 8'd1;
      end else begin
        r.cmd       = CMD_READ_ID;
        r.frame_len = 8'd7;
        r.read_code = 8'd1;
        r.object_id = 8'd0;
      end
      if (mode >= 65) begin
        case ($urandom_range(6))
          0: r.frame_len  = 8'($urandom_range(12));
          1: r.addr_hi    = 8'($urandom);
          2: r.addr_lo    = 8'($urandom_range(9));
          3: r.quantity   = $urandom_range(1) ? 16'($urandom_range(12)) : 16'($urandom);
          4: r.byte_count = 8'($urandom_range(3));
          5: r.read_code  = 8'($urandom_range(3));
          default: r.object_id = 8'($urandom_range(3));
        endcase
      end
    end
    return r;
  endfunction

  // Entered and left at a falling edge; tvalid stays high into the next call
  // unless that call idles first.
  task automatic send_req(input req_t r, input bit typed, input status_e st);
    while ($urandom_range(99) < s_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= 88'(r);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_response(r);
    if (typed) begin
      pending_resp.push_back('{st, 8'h00, 1'b1, relay_state});
    end else begin
      foreach (staged_resp[i]) pending_resp.push_back(staged_resp[i]);
    end
    @(negedge clk_i);
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_limit(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_MAX_READ_COILS:  lim_read_coils  = value[CfgW-1:0];
      REG_MAX_READ_INPUTS: lim_read_inputs = value[CfgW-1:0];
      default:             lim_write_coils = value[CfgW-1:0];
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_limits(input logic [31:0] rc, input logic [31:0] ri,
                            input logic [31:0] wc);
    write_limit(REG_MAX_READ_COILS, rc);
    write_limit(REG_MAX_READ_INPUTS, ri);
    write_limit(REG_MAX_WRITE_COILS, wc);
  endtask

  task automatic run_random(input int n_items, input int s_pct, input int r_pct);
    req_t r;
    int   n;
    s_idle_pct  = s_pct;
    r_stall_pct = r_pct;
    n = 0;
    while (n < n_items) begin
      r = random_request();
      send_req(r, 1'b0, ST_OK);
      // Unused command codes are dropped by the block and are not counted.
      if (r.cmd <= CMD_READ_ID) n++;
    end
    settle_block();
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= r_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    resp_t got;
    resp_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = status_e'(m_axis_tdata[1:0]);
      got.data   = m_axis_tdata[9:2];
      got.relay  = m_axis_tdata[13:10];
      got.last   = m_axis_tlast;
      if (pending_resp.size() == 0) begin
        report_mismatch($sformatf("item with nothing expected, data %h", m_axis_tdata));
      end else begin
        want = pending_resp.pop_front();
        if (got.status != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.data != want.data)
          report_mismatch($sformatf("resp_byte %h, expected %h", got.data, want.data));
        if (got.last != want.last)
          report_mismatch($sformatf("tlast %b, expected %b", got.last, want.last));
        if (got.relay != want.relay)
          report_mismatch($sformatf("relay_drive %h, expected %h", got.relay, want.relay));
      end
    end
  end

  initial begin
    #8000000;
    $display("tb_modbus_dio_function_handler: done, errors");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    lim_read_coils  = 11'd4;
    lim_read_inputs = 11'd8;
    lim_write_coils = 11'd4;
    relay_state     = 4'h0;

    dir_tab.push_back('{mk_req(CMD_READ_COILS, 8, 0, 0, 4, 0, 0, 0, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_READ_INPUTS, 8, 0, 0, 8, 0, 0, 0, 0, 8'hA5), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_READ_INPUTS, 8, 0, 7, 1, 0, 0, 0, 0, 8'h80), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_WRITE_COIL, 8, 0, 0, COIL_ON, 0, 0, 0, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_WRITE_COIL, 8, 0, 3, COIL_ON, 0, 0, 0, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_WRITE_COIL, 8, 0, 3, COIL_OFF, 0, 0, 0, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_WRITE_COIL, 8, 0, 0, 16'h1234, 0, 0, 0, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_WRITE_COIL, 8, 0, 0, 16'hFF01, 0, 0, 0, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_WRITE_COIL, 8, 0, 4, COIL_ON, 0, 0, 0, 0, 0), 1'b1, ST_ADDR});
    dir_tab.push_back('{mk_req(CMD_WRITE_COIL, 8, 8'hFF, 0, COIL_ON, 0, 0, 0, 0, 0), 1'b1, ST_ADDR});
    dir_tab.push_back('{mk_req(CMD_WRITE_COILS, 10, 0, 0, 4, 1, 8'hFF, 0, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_WRITE_COILS, 10, 0, 2, 2, 1, 8'h00, 0, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_WRITE_COILS, 10, 0, 0, 4, 2, 8'hFF, 0, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_WRITE_COILS, 10, 0, 0, 5, 1, 8'hFF, 0, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_WRITE_COILS, 8, 0, 0, 1, 1, 8'hFF, 0, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_WRITE_COILS, 10, 0, 3, 2, 1, 8'hFF, 0, 0, 0), 1'b1, ST_ADDR});
    dir_tab.push_back('{mk_req(CMD_READ_COILS, 8, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_READ_COILS, 8, 0, 0, 5, 0, 0, 0, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_READ_COILS, 7, 0, 0, 1, 0, 0, 0, 0, 0), 1'b1, ST_VALUE});
    // The end address overruns the coils although the start is in range.
    dir_tab.push_back('{mk_req(CMD_READ_COILS, 8, 0, 1, 4, 0, 0, 0, 0, 0), 1'b1, ST_ADDR});
    dir_tab.push_back('{mk_req(CMD_READ_INPUTS, 8, 8'hFF, 0, 1, 0, 0, 0, 0, 0), 1'b1, ST_ADDR});
    dir_tab.push_back('{mk_req(CMD_READ_INPUTS, 8'hFF, 0, 8'hFF, 16'hFFFF, 0, 0, 0, 0, 8'hFF),
                        1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_READ_ID, 7, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_READ_ID, 8, 0, 0, 0, 0, 0, 1, 8'hFF, 0), 1'b1, ST_ADDR});
    dir_tab.push_back('{mk_req(CMD_READ_ID, 7, 0, 0, 0, 0, 0, 8'hFF, 0, 0), 1'b1, ST_VALUE});
    dir_tab.push_back('{mk_req(CMD_SPARE_LO, 8, 0, 0, 1, 0, 0, 0, 0, 0), 1'b0, ST_OK});
    dir_tab.push_back('{mk_req(CMD_SPARE_HI, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF,
                               8'hFF, 8'hFF, 8'hFF), 1'b0, ST_OK});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].st);
    settle_block();

    // With every limit at zero each read or multi-coil write quantity is refused.
    set_limits(32'd0, 32'd0, 32'd0);
    run_random(20, 65, 0);

    // The receiver holds off while requests keep coming, so the block backs up.
    set_limits(32'd2000, 32'd2000, 32'd1968);
    hold_left = 300;
    run_random(60, 0, 65);

    // Upper bits beyond the register width are dropped.
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(50, 25, 25);

    set_limits($urandom_range(8, 1), $urandom_range(8, 1), $urandom_range(4, 1));
    run_random(70, 0, 0);

    set_limits(32'd4, 32'd8, 32'd4);
    run_random(60, 65, 0);

    if (mismatch_cnt == 0) begin
      $display("tb_modbus_dio_function_handler: done, clean");
    end else begin
      $display("tb_modbus_dio_function_handler: done, errors");
    end
    $finish;
  end

endmodule
